// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/shabs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Types, constants and round functions shared by the controller and datapath.
// ----------------------------------------------------------------------------
package shabs_pkg;

  // Padding marker byte that follows the last message byte.
  localparam logic [7:0] PadMark = 8'h80;

  // Width of the message byte counter; the bit count is this plus three bits.
  localparam int unsigned LenW = 61;

  // Block position where the length field starts.
  localparam logic [5:0] LenPos = 6'd56;

  // Initial hash value, word 0 (H0) in the lowest slot.
  localparam logic [7:0][31:0] InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // Source of the byte written into the block buffer.
  typedef enum logic [1:0] {
    BYTE_IN,
    BYTE_MARK,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;    // write one byte into the block buffer
    byte_sel_e sel;     // which byte to write
    logic      count;   // count one message byte
    logic      start;   // copy the chain value into the working variables
    logic      round;   // run one compression round
    logic [5:0] rnd;    // round number
    logic      finish;  // add the working variables into the chain value
    logic      emit;    // hand the digest to the output stage and clear
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] byte_cnt;  // bytes held in the current block
    logic       out_busy;  // digest words still waiting to be taken
  } status_t;

  // Round constants.
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Compression sigma on the first working variable.
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // Compression sigma on the fifth working variable.
  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Message schedule sigma on the word fifteen rounds back.
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // Message schedule sigma on the word two rounds back.
  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// File: rtl/core/shabs_if.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher channels
// Valid/ready channels for message byte requests and digest word requests.
// ----------------------------------------------------------------------------

// Message byte channel.
interface shabs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

// Digest word channel.
interface shabs_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

// File: rtl/core/shabs_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher controller
// Sequences byte intake, padding, the 64 compression rounds and digest hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shabs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_has_byte_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  shabs_pkg::status_t status_i,
  output shabs_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FINISH,
    S_DIGEST
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic       fin_q, fin_d;    // message end seen, padding pending or running
  logic       mark_q, mark_d;  // padding marker byte written
  logic       len_q, len_d;    // length field started
  logic       block_full;

  // The byte written this cycle completes the block.
  assign block_full = (status_i.byte_cnt == 6'd63);
  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    fin_d      = fin_q;
    mark_d     = mark_q;
    len_d      = len_q;
    cmd_o      = '0;
    cmd_o.sel  = shabs_pkg::BYTE_IN;
    cmd_o.rnd  = rnd_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_has_byte_i) begin
            cmd_o.load  = 1'b1;
            cmd_o.count = 1'b1;
            if (block_full) begin
              cmd_o.start = 1'b1;
              state_d     = S_ROUND;
            end
          end
          if (in_last_i) begin
            fin_d = 1'b1;
            if (!(in_has_byte_i && block_full)) begin
              state_d = S_PAD;
            end
          end
        end
      end
      S_PAD: begin
        // Marker first, then zeros up to the length field, then the length.
        cmd_o.load = 1'b1;
        if (!mark_q) begin
          cmd_o.sel = shabs_pkg::BYTE_MARK;
          mark_d    = 1'b1;
        end else if (!len_q && (status_i.byte_cnt != shabs_pkg::LenPos)) begin
          cmd_o.sel = shabs_pkg::BYTE_ZERO;
        end else begin
          cmd_o.sel = shabs_pkg::BYTE_LEN;
          len_d     = 1'b1;
        end
        if (block_full) begin
          cmd_o.start = 1'b1;
          state_d     = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        if (!fin_q) begin
          state_d = S_IDLE;
        end else if (len_q) begin
          state_d = S_DIGEST;
        end else begin
          state_d = S_PAD;
        end
      end
      S_DIGEST: begin
        // Wait until the previous digest has drained from the output stage.
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          fin_d      = 1'b0;
          mark_d     = 1'b0;
          len_d      = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rnd_q   <= 6'd0;
      fin_q   <= 1'b0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      fin_q   <= fin_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
    end
  end

  `ASSERT_IMPLIES(a_rnd_only_in_round, state_q != S_ROUND, rnd_q == 6'd0, "round count off")
  `ASSERT_IMPLIES(a_len_after_mark, len_q, mark_q && fin_q, "length field before marker")
  `ASSERT_NEXT(a_round_then_finish, rnd_q == 6'd63, state_q == S_FINISH, "no finish step")

endmodule

// File: rtl/core/shabs_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher datapath
// Block buffer as a 16-word schedule shift line, round unit, chain value,
// message length counter and the digest output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shabs_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  shabs_pkg::cmd_t    cmd_i,
  output shabs_pkg::status_t status_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_index_o,
  output logic               last_word_o
);

  logic [15:0][31:0]              win_q, win_d;
  logic [23:0]                    acc_q, acc_d;
  logic [5:0]                     cnt_q, cnt_d;
  logic [shabs_pkg::LenW-1:0]     len_q, len_d;
  logic [7:0][31:0]               chain_q, chain_d;
  logic [7:0][31:0]               work_q, work_d;
  logic [7:0][31:0]               outw_q, outw_d;
  logic                           ov_q, ov_d;
  logic [2:0]                     idx_q, idx_d;
  logic [shabs_pkg::LenW+2:0]     bit_len;
  logic [5:0]                     len_shift;
  logic [7:0]                     len_byte;
  logic [7:0]                     byte_val;
  logic [31:0]                    ch, maj, t1, t2, new_w;

  // Length field byte: big-endian byte of the bit count at this block position.
  assign bit_len   = {len_q, 3'b000};
  assign len_shift = {~cnt_q[2:0], 3'b000};
  assign len_byte  = 8'(bit_len >> len_shift);

  // Byte written into the block buffer.
  always_comb begin
    case (cmd_i.sel)
      shabs_pkg::BYTE_IN:   byte_val = data_byte_i;
      shabs_pkg::BYTE_MARK: byte_val = shabs_pkg::PadMark;
      shabs_pkg::BYTE_ZERO: byte_val = 8'h00;
      shabs_pkg::BYTE_LEN:  byte_val = len_byte;
      default:              byte_val = 8'h00;
    endcase
  end

  // One compression round and the schedule word sixteen rounds ahead.
  assign ch    = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign maj   = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
  assign t1    = work_q[7] + shabs_pkg::big_sigma1(work_q[4]) + ch
                 + shabs_pkg::round_k(cmd_i.rnd) + win_q[0];
  assign t2    = shabs_pkg::big_sigma0(work_q[0]) + maj;
  assign new_w = shabs_pkg::small_sigma1(win_q[14]) + win_q[9]
                 + shabs_pkg::small_sigma0(win_q[1]) + win_q[0];

  // Next values.
  always_comb begin
    win_d   = win_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    chain_d = chain_q;
    work_d  = work_q;
    outw_d  = outw_q;
    ov_d    = ov_q;
    idx_d   = idx_q;

    // Pack bytes big-endian; each fourth byte shifts a whole word into the window.
    if (cmd_i.load) begin
      acc_d = {acc_q[15:0], byte_val};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q[1:0] == 2'b11) begin
        win_d = {{acc_q, byte_val}, win_q[15:1]};
      end
    end

    if (cmd_i.count) begin
      len_d = len_q + shabs_pkg::LenW'(1);
    end

    if (cmd_i.start) begin
      work_d = chain_q;
    end

    if (cmd_i.round) begin
      work_d = {work_q[6], work_q[5], work_q[4], work_q[3] + t1,
                work_q[2], work_q[1], work_q[0], t1 + t2};
      win_d  = {new_w, win_q[15:1]};
    end

    if (cmd_i.finish) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
    end

    // Drain digest words, H0 first.
    if (ov_q && out_ready_i) begin
      outw_d = {32'h0, outw_q[7:1]};
      idx_d  = idx_q + 3'd1;
      if (idx_q == 3'd7) begin
        ov_d = 1'b0;
      end
    end

    // Hand the digest over and start a new message.
    if (cmd_i.emit) begin
      outw_d  = chain_q;
      ov_d    = 1'b1;
      idx_d   = 3'd0;
      chain_d = shabs_pkg::InitHash;
      len_d   = '0;
    end
  end

  // Control and chain state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 6'd0;
      len_q   <= '0;
      chain_q <= shabs_pkg::InitHash;
      ov_q    <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      chain_q <= chain_d;
      ov_q    <= ov_d;
      idx_q   <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    acc_q  <= acc_d;
    work_q <= work_d;
    outw_q <= outw_d;
  end

  assign status_o.byte_cnt = cnt_q;
  assign status_o.out_busy = ov_q;
  assign out_valid_o       = ov_q;
  assign digest_word_o     = outw_q[0];
  assign word_index_o      = idx_q;
  assign last_word_o       = (idx_q == 3'd7);

  `ASSERT_IMPLIES(a_emit_when_free, cmd_i.emit, !ov_q, "digest emitted over a pending one")
  `ASSERT_ALWAYS(a_load_xor_round, !(cmd_i.load && cmd_i.round), "byte load during a round")

endmodule

// File: rtl/core/sha256_byte_stream_hasher.sv
// A byte request is taken while the hasher is idle; a request that fills a block
// then holds off input while the single round unit runs the 64 rounds and the
// chain value is updated, so no new byte is taken during a block's compression.
// A last request adds the padding bytes (9 to 72), the rounds of each padded
// block and the hand-off; eight digest words then leave one per cycle while ready.
// Reset is asynchronous: the chain value returns to the initial hash value.
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and returns the eight digest words of each message.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input logic                  clk_i,
  input logic                  rst_ni,
  shabs_byte_if.sink           byte_i,
  shabs_digest_if.source       digest_o
);

  shabs_pkg::cmd_t    cmd;
  shabs_pkg::status_t status;

  // Sequencer for intake, padding and rounds.
  shabs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (byte_i.valid),
    .in_has_byte_i (byte_i.has_byte),
    .in_last_i     (byte_i.last),
    .in_ready_o    (byte_i.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Block buffer, round unit and output stage.
  shabs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .data_byte_i   (byte_i.data_byte),
    .out_valid_o   (digest_o.valid),
    .out_ready_i   (digest_o.ready),
    .digest_word_o (digest_o.digest_word),
    .word_index_o  (digest_o.word_index),
    .last_word_o   (digest_o.last_word)
  );

endmodule
